[src/wms_pkg.sv]
`default_nettype none
package wms_pkg;

    localparam int HIDDEN_UNITS_DEF = 25;
    localparam int WINDOW_WORDS_DEF = 5;
    localparam int VECTOR_DIM_DEF   = 50;

    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 16;
    localparam int SCORE_W = 13;
    localparam int ACC_W   = 48;

    localparam logic [12:0] HALF_Q12 = 13'd2048;

    typedef enum logic [1:0] {
        OP_WR_HID = 2'd0,
        OP_WR_OUT = 2'd1,
        OP_WR_WIN = 2'd2,
        OP_EVAL   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_TANH     = 2'd0,
        ACT_SIGMOID  = 2'd1,
        ACT_SOFTPLUS = 2'd2,
        ACT_SPARE    = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN,
        ST_ACT,
        ST_OUT,
        ST_FINAL,
        ST_EMIT
    } t_state;

    // Control handed from the sequencer to each cell of the chain.
    typedef struct packed {
        logic clear;
        logic acc_en;
        logic bias;
    } t_cell_ctl;

    // Q8.24 sum to Q4.12: round half up, then saturate.
    function automatic logic signed [15:0] to_q12(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-13:0] q;
        begin
            t = v + ACC_W'(2048);
            q = t[ACC_W-1:12];
            if (q > 32767) to_q12 = 16'sh7fff;
            else if (q < -32768) to_q12 = 16'sh8000;
            else to_q12 = q[15:0];
        end
    endfunction

    function automatic logic signed [15:0] tab_val(input logic [1:0] sel, input logic [6:0] i);
        logic signed [15:0] t [65];
        logic signed [15:0] s [65];
        logic signed [15:0] p [65];
        begin
            t = '{-4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096,
                  -4096, -4096, -4096, -4095, -4095, -4094, -4093, -4091, -4089, -4084,
                  -4076, -4063, -4041, -4006, -3949, -3856, -3707, -3475, -3119, -2602,
                  -1893, -1003, 0, 1003, 1893, 2602, 3119, 3475, 3707, 3856,
                  3949, 4006, 4041, 4063, 4076, 4084, 4089, 4091, 4093, 4094,
                  4095, 4095, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                  4096, 4096, 4096, 4096, 4096};
            s = '{1, 2, 2, 3, 4, 5, 6, 8, 10, 13,
                  17, 21, 27, 35, 45, 58, 74, 94, 120, 153,
                  194, 246, 311, 391, 488, 606, 747, 912, 1102, 1314,
                  1546, 1793, 2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490,
                  3608, 3705, 3785, 3850, 3902, 3943, 3976, 4002, 4022, 4038,
                  4051, 4061, 4069, 4075, 4079, 4083, 4086, 4088, 4090, 4091,
                  4092, 4093, 4094, 4094, 4095};
            p = '{1, 2, 2, 3, 4, 5, 6, 8, 10, 13,
                  17, 21, 28, 35, 45, 58, 74, 95, 122, 156,
                  199, 254, 323, 410, 520, 656, 825, 1032, 1283, 1585,
                  1942, 2359, 2839, 3383, 3990, 4657, 5379, 6152, 6969, 7824,
                  8712, 9626, 10563, 11518, 12487, 13468, 14458, 15455, 16458, 17466,
                  18477, 19491, 20508, 21525, 22545, 23565, 24586, 25608, 26630, 27653,
                  28676, 29699, 30722, 31746, 32767};
            case (sel)
                ACT_SIGMOID:  tab_val = s[i];
                ACT_SOFTPLUS: tab_val = p[i];
                default:      tab_val = t[i];
            endcase
        end
    endfunction

    // Piecewise-linear lookup over 64 segments of [-8,8).
    function automatic logic signed [15:0] pwl(input logic [1:0] sel,
                                               input logic signed [15:0] x);
        logic [15:0] u;
        logic [6:0] i;
        logic signed [11:0] f;
        logic signed [15:0] y0;
        logic signed [16:0] d;
        logic signed [28:0] m;
        logic signed [28:0] q;
        begin
            u  = x ^ 16'h8000;
            i  = {1'b0, u[15:10]};
            f  = {2'b00, u[9:0]};
            y0 = tab_val(sel, i);
            d  = 17'(tab_val(sel, i + 7'd1)) - 17'(y0);
            m  = 29'(d) * 29'(f) + 29'sd512;
            // Division truncating toward zero, as the table math expects.
            q  = (m < 0) ? -((-m) >>> 10) : (m >>> 10);
            pwl = y0 + q[15:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/wms_if.sv]
`default_nettype none
interface wms_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [12:0] address;
    logic signed [15:0] value;
    modport source (output valid, opcode, address, value, input ready);
    modport sink   (input valid, opcode, address, value, output ready);
endinterface

interface wms_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] score;
    logic        tag_decision;
    modport source (output valid, score, tag_decision, input ready);
    modport sink   (input valid, score, tag_decision, output ready);
endinterface

interface wms_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] activation_mode;
    modport source (output valid, activation_mode, input ready);
    modport sink   (input valid, activation_mode, output ready);
endinterface
`default_nettype wire

[src/wms_cell.sv]
`default_nettype none
// One hidden unit: holds its weight row in a private memory and one
// accumulator. The window element arrives from the left neighbor and is
// passed to the right neighbor in the next cycle, together with its column.
module wms_cell
    import wms_pkg::*;
#(
    parameter int ROW_LEN = 251,
    parameter int COL_W   = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_we,
    input  wire logic [COL_W-1:0]        i_wcol,
    input  wire logic signed [15:0]      i_wdata,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic [COL_W-1:0]        i_col,
    input  wire logic signed [15:0]      i_x,
    output      t_cell_ctl               o_ctl,
    output      logic [COL_W-1:0]        o_col,
    output      logic signed [15:0]      o_x,
    output      logic signed [ACC_W-1:0] o_acc
);
    logic signed [15:0] r_mem [ROW_LEN];
    logic signed [15:0] r_w;
    logic signed [15:0] r_xd;
    t_cell_ctl          r_ctl;
    logic [COL_W-1:0]   r_col;
    logic signed [15:0] r_x;
    logic signed [31:0] r_prod;
    t_cell_ctl          r_pctl;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wcol] <= i_wdata;
        end
        r_w   <= r_mem[i_col];
        r_xd  <= i_x;
        r_col <= i_col;
        r_x   <= i_x;
        r_prod <= r_w * (r_ctl.bias ? 16'sd4096 : r_xd);
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_pctl <= '0;
        end else begin
            r_ctl  <= i_ctl;
            r_pctl <= r_ctl;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_pctl.clear) n_acc = '0;
        else if (r_pctl.acc_en) n_acc = r_acc + ACC_W'(r_prod);
    end

    assign o_ctl = r_ctl;
    assign o_col = r_col;
    assign o_x   = r_x;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

[src/wms_seq.sv]
`default_nettype none
// Evaluation sequencer.
module wms_seq
    import wms_pkg::*;
#(
    parameter int IN_LEN  = 250,
    parameter int HIDDEN  = 25,
    parameter int COL_W   = 8,
    parameter int HID_W   = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_out_ready,
    output      t_state           o_state,
    output      t_cell_ctl        o_ctl,
    output      logic [COL_W-1:0] o_col,
    output      logic [HID_W-1:0] o_unit
);
    localparam int DRAIN = HIDDEN + 4;
    localparam int CNT_W = $clog2(DRAIN + IN_LEN + 2);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The output state is held so that the last product has
    // reached the output sum before the final sigmoid reads it.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 1'b1;
        case (r_state)
            ST_IDLE:  begin n_cnt = '0; if (i_start) n_state = ST_BIAS; end
            ST_BIAS:  begin n_cnt = '0; n_state = ST_MAC; end
            ST_MAC:   if (r_cnt == CNT_W'(IN_LEN - 1)) begin
                          n_cnt = '0; n_state = ST_DRAIN;
                      end
            ST_DRAIN: if (r_cnt == CNT_W'(DRAIN)) begin
                          n_cnt = '0; n_state = ST_ACT;
                      end
            ST_ACT:   if (r_cnt == CNT_W'(HIDDEN - 1)) begin
                          n_cnt = '0; n_state = ST_OUT;
                      end
            ST_OUT:   if (r_cnt == CNT_W'(1)) begin
                          n_cnt = '0; n_state = ST_FINAL;
                      end
            ST_FINAL: begin n_cnt = '0; n_state = ST_EMIT; end
            ST_EMIT:  begin n_cnt = '0; if (i_out_ready) n_state = ST_IDLE; end
            default:  begin n_cnt = '0; n_state = ST_IDLE; end
        endcase
    end

    always_comb begin
        o_ctl  = '0;
        o_col  = '0;
        o_unit = '0;
        case (r_state)
            ST_IDLE: o_ctl.clear = i_start;
            ST_BIAS: begin
                o_ctl.acc_en = 1'b1;
                o_ctl.bias   = 1'b1;
                o_col        = COL_W'(IN_LEN);
            end
            ST_MAC: begin
                o_ctl.acc_en = 1'b1;
                o_col        = r_cnt[COL_W-1:0];
            end
            ST_ACT: o_unit = r_cnt[HID_W-1:0];
            default: ;
        endcase
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

[src/window_mlp_score.sv]
`default_nettype none
// Channel   Dir  Payload                          Transaction when
// i_in      in   opcode, address, value           valid && ready
// i_cfg     in   activation_mode                  valid && ready
// o_out     out  score, tag_decision              valid && ready
//
// A write transaction produces no result. An evaluate
// transaction streams the window through a chain of HIDDEN_UNITS cells, one
// element per cycle. The delay until the result is offered is set by the
// chain's one multiplier per cell and the shared activation unit that
// visits the units one per cycle. Input ready returns in the cycle after
// the result transaction.
// Reset clears control state only; the stores are undefined until written.
// Input ready is low while an evaluation runs or its result waits.
module window_mlp_score
    import wms_pkg::*;
#(
    parameter int HIDDEN_UNITS = HIDDEN_UNITS_DEF,
    parameter int WINDOW_WORDS = WINDOW_WORDS_DEF,
    parameter int VECTOR_DIM   = VECTOR_DIM_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    wms_in_if.sink   i_in,
    wms_cfg_if.sink  i_cfg,
    wms_out_if.source o_out
);
    localparam int IN_LEN  = WINDOW_WORDS * VECTOR_DIM;
    localparam int ROW_LEN = IN_LEN + 1;
    localparam int COL_W   = $clog2(ROW_LEN + 1);
    localparam int HID_W   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int WIN_W   = (IN_LEN > 1) ? $clog2(IN_LEN) : 1;

    t_state           w_state;
    t_cell_ctl        w_ctl;
    logic [COL_W-1:0] w_col;
    logic [HID_W-1:0] w_unit;
    logic [1:0]       r_mode;
    logic signed [15:0] r_win [IN_LEN];
    logic signed [15:0] r_vw  [HIDDEN_UNITS];
    logic signed [15:0] r_x;
    logic [COL_W-1:0] r_xcol;
    t_cell_ctl        r_xctl;
    logic signed [ACC_W-1:0] r_osum;
    logic signed [15:0] r_h;
    logic signed [31:0] r_op;
    logic               r_op_v;
    logic [12:0]        r_score;
    logic [HID_W-1:0]   r_unit_d;
    logic               r_act_v;

    logic               w_acc_in;
    logic               w_idle;
    logic [ADDR_W-1:0]  w_row_q;
    logic [ADDR_W-1:0]  w_col_r;

    assign w_idle    = (w_state == ST_IDLE);
    assign i_in.ready = w_idle;
    assign i_cfg.ready = 1'b1;
    assign w_acc_in  = i_in.valid && i_in.ready;

    // Split a hidden weight address into row and column by stepping a
    // constant row length: a multiply by reciprocal is avoided with a
    // small compare chain over rows.
    always_comb begin
        w_row_q = '0;
        w_col_r = i_in.address;
        for (int r = 1; r < HIDDEN_UNITS; r++) begin
            if (i_in.address >= ADDR_W'(r * ROW_LEN)) begin
                w_row_q = ADDR_W'(r);
                w_col_r = i_in.address - ADDR_W'(r * ROW_LEN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= ACT_TANH;
        else if (i_cfg.valid) r_mode <= i_cfg.activation_mode;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_in.opcode == OP_WR_WIN && i_in.address < ADDR_W'(IN_LEN))
            r_win[i_in.address[WIN_W-1:0]] <= i_in.value;
        if (w_acc_in && i_in.opcode == OP_WR_OUT && i_in.address < ADDR_W'(HIDDEN_UNITS))
            r_vw[i_in.address[HID_W-1:0]] <= i_in.value;
        r_x    <= r_win[w_col[WIN_W-1:0]];
        r_xcol <= w_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_xctl <= '0;
        else r_xctl <= w_ctl;
    end

    wms_seq #(.IN_LEN(IN_LEN), .HIDDEN(HIDDEN_UNITS), .COL_W(COL_W), .HID_W(HID_W))
    u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_acc_in && i_in.opcode == OP_EVAL),
        .i_out_ready(o_out.ready),
        .o_state(w_state), .o_ctl(w_ctl), .o_col(w_col), .o_unit(w_unit)
    );

    t_cell_ctl          c_ctl [HIDDEN_UNITS+1];
    logic [COL_W-1:0]   c_col [HIDDEN_UNITS+1];
    logic signed [15:0] c_x   [HIDDEN_UNITS+1];
    logic signed [ACC_W-1:0] c_acc [HIDDEN_UNITS];

    assign c_ctl[0] = r_xctl;
    assign c_col[0] = r_xcol;
    assign c_x[0]   = r_x;

    for (genvar g = 0; g < HIDDEN_UNITS; g++) begin : g_cell
        wms_cell #(.ROW_LEN(ROW_LEN), .COL_W(COL_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_we(w_acc_in && i_in.opcode == OP_WR_HID
                  && i_in.address < ADDR_W'(HIDDEN_UNITS * ROW_LEN)
                  && w_row_q == ADDR_W'(g)),
            .i_wcol(w_col_r[COL_W-1:0]), .i_wdata(i_in.value),
            .i_ctl(c_ctl[g]), .i_col(c_col[g]), .i_x(c_x[g]),
            .o_ctl(c_ctl[g+1]), .o_col(c_col[g+1]), .o_x(c_x[g+1]),
            .o_acc(c_acc[g])
        );
    end

    // Output layer: one activation and one product per cycle, then summed.
    always_ff @(posedge i_clk) begin
        r_unit_d <= w_unit;
        r_h      <= pwl(r_mode, to_q12(c_acc[w_unit]));
        r_op     <= r_vw[r_unit_d] * r_h;
        if (w_state == ST_BIAS) r_osum <= '0;
        else if (r_op_v) r_osum <= r_osum + ACC_W'(r_op);
        if (w_state == ST_FINAL) begin
            r_score <= 13'(pwl(ACT_SIGMOID, to_q12(r_osum)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_v <= 1'b0;
            r_op_v  <= 1'b0;
        end else begin
            r_act_v <= (w_state == ST_ACT);
            r_op_v  <= r_act_v;
        end
    end

    assign o_out.valid        = (w_state == ST_EMIT);
    assign o_out.score        = r_score;
    assign o_out.tag_decision = (r_score > HALF_Q12);

    // Assertions.
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("result shown while input open");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.score))
        else $error("result dropped under stall");
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.score <= 13'd4096)
        else $error("score above one");
endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import wms_pkg::*;

    // Store sizes at the block's default parameters.
    localparam int UNITS    = HIDDEN_UNITS_DEF;
    localparam int IN_LEN   = WINDOW_WORDS_DEF * VECTOR_DIM_DEF;
    localparam int ROW_LEN  = IN_LEN + 1;
    localparam int HID_LEN  = UNITS * ROW_LEN;
    // Quiet time waited after the last score has come back.
    localparam int SETTLE   = 400;
    // Cycles without any transaction before the run is declared hung.
    localparam int HANG_LIMIT = 5000;

    localparam int TANH_TAB[65] = '{
        -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096,
        -4096, -4096, -4096, -4095, -4095, -4094, -4093, -4091, -4089, -4084,
        -4076, -4063, -4041, -4006, -3949, -3856, -3707, -3475, -3119, -2602,
        -1893, -1003, 0, 1003, 1893, 2602, 3119, 3475, 3707, 3856,
        3949, 4006, 4041, 4063, 4076, 4084, 4089, 4091, 4093, 4094,
        4095, 4095, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
        4096, 4096, 4096, 4096, 4096};
    localparam int SIG_TAB[65] = '{
        1, 2, 2, 3, 4, 5, 6, 8, 10, 13,
        17, 21, 27, 35, 45, 58, 74, 94, 120, 153,
        194, 246, 311, 391, 488, 606, 747, 912, 1102, 1314,
        1546, 1793, 2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490,
        3608, 3705, 3785, 3850, 3902, 3943, 3976, 4002, 4022, 4038,
        4051, 4061, 4069, 4075, 4079, 4083, 4086, 4088, 4090, 4091,
        4092, 4093, 4094, 4094, 4095};
    localparam int SOFTPLUS_TAB[65] = '{
        1, 2, 2, 3, 4, 5, 6, 8, 10, 13,
        17, 21, 28, 35, 45, 58, 74, 95, 122, 156,
        199, 254, 323, 410, 520, 656, 825, 1032, 1283, 1585,
        1942, 2359, 2839, 3383, 3990, 4657, 5379, 6152, 6969, 7824,
        8712, 9626, 10563, 11518, 12487, 13468, 14458, 15455, 16458, 17466,
        18477, 19491, 20508, 21525, 22545, 23565, 24586, 25608, 26630, 27653,
        28676, 29699, 30722, 31746, 32767};

    typedef struct {
        logic [12:0] score;
        logic        tag_decision;
    } t_score;

    logic i_clk;
    logic i_rst_n;

    wms_in_if  in_ch ();
    wms_cfg_if cfg_ch ();
    wms_out_if out_ch ();

    window_mlp_score u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    // The testbench's own copy of the block's stores and mode register.
    logic signed [15:0] hid_store [HID_LEN];
    logic signed [15:0] out_store [UNITS];
    logic signed [15:0] win_store [IN_LEN];
    t_act               act_mode;

    t_score pending_scores [$];
    int     mismatches;
    int     quiet_cycles;
    // When set, neither side inserts idle cycles.
    bit     calm;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report(input string what);
        $display("[%0t] %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int table_at(input t_act sel, input int idx);
        case (sel)
            ACT_SIGMOID:  return SIG_TAB[idx];
            ACT_SOFTPLUS: return SOFTPLUS_TAB[idx];
            default:      return TANH_TAB[idx];
        endcase
    endfunction

    // Sum in Q8.24 to Q4.12: round half up, floor, saturate.
    function automatic int round_sat_q12(input longint sum);
        longint q;
        q = (sum + 2048) >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    // Piecewise-linear curve; integer division truncates toward zero here.
    function automatic int curve(input t_act sel, input int x);
        int u;
        int idx;
        int frac;
        int y0;
        int d;
        u    = x + 32768;
        idx  = u >> 10;
        frac = u & 1023;
        y0   = table_at(sel, idx);
        d    = table_at(sel, idx + 1) - y0;
        return y0 + (d * frac + 512) / 1024;
    endfunction

    // Full forward pass over the current stores.
    function automatic t_score score_window();
        longint  hsum;
        longint  osum;
        int      h;
        int      sc;
        t_score  res;
        osum = 0;
        for (int r = 0; r < UNITS; r++) begin
            hsum = longint'(hid_store[r * ROW_LEN + IN_LEN]) * 4096;
            for (int c = 0; c < IN_LEN; c++) begin
                hsum += longint'(hid_store[r * ROW_LEN + c]) * longint'(win_store[c]);
            end
            h = curve(act_mode, round_sat_q12(hsum));
            osum += longint'(out_store[r]) * longint'(h);
        end
        sc = curve(ACT_SIGMOID, round_sat_q12(osum));
        res.score        = sc[12:0];
        res.tag_decision = (sc > 2048);
        return res;
    endfunction

    // Updates the model for one accepted item; an evaluate queues a score.
    task automatic predict_item(input t_opcode op, input logic [12:0] addr,
                                input logic signed [15:0] val);
        case (op)
            OP_WR_HID: if (addr < HID_LEN) hid_store[addr] = val;
            OP_WR_OUT: if (addr < UNITS) out_store[addr] = val;
            OP_WR_WIN: if (addr < IN_LEN) win_store[addr] = val;
            default:   pending_scores = {pending_scores, score_window()};
        endcase
    endtask

    // Optional idle burst on the input side before the next item.
    task automatic maybe_idle_input();
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Sends one item and waits for its transaction.
    task automatic send_item(input t_opcode op, input logic [12:0] addr,
                             input logic signed [15:0] val);
        maybe_idle_input();
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.address <= addr;
        in_ch.value   <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(op, addr, val);
    endtask

    // Waits until every score has come back and the block has gone quiet.
    task automatic drain_scores();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mode register is only written while the block is idle.
    task automatic set_mode(input t_act mode);
        drain_scores();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.activation_mode <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        act_mode = mode;
    endtask

    // Mostly small values, so that sums stay in the interesting range.
    function automatic logic signed [15:0] rand_value(input int span);
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * span - 1) - span);
    endfunction

    // Every store entry is written before the first evaluation.
    task automatic test_fill_stores();
        for (int a = 0; a < HID_LEN; a++) send_item(OP_WR_HID, 13'(a), rand_value(512));
        for (int a = 0; a < UNITS; a++) send_item(OP_WR_OUT, 13'(a), rand_value(4096));
        for (int a = 0; a < IN_LEN; a++) send_item(OP_WR_WIN, 13'(a), rand_value(4096));
        send_item(OP_EVAL, 13'h0000, 16'sh0000);
    endtask

    // Extremes of the fields, writes past the end of each store, and
    // evaluations with arbitrary operands in every mode.
    task automatic test_directed();
        send_item(OP_WR_HID, 13'(HID_LEN), 16'sh7fff);
        send_item(OP_WR_HID, 13'h1fff, 16'sh8000);
        send_item(OP_WR_OUT, 13'(UNITS), 16'sh7fff);
        send_item(OP_WR_WIN, 13'(IN_LEN), 16'sh7fff);
        send_item(OP_WR_WIN, 13'h1fff, 16'sh8000);
        send_item(OP_EVAL, 13'h1fff, 16'sh8000);
        // Drive the first hidden unit hard positive to hit the top table end.
        send_item(OP_WR_HID, 13'(IN_LEN), 16'sh7fff);
        send_item(OP_WR_HID, 13'h0000, 16'sh8000);
        send_item(OP_WR_WIN, 13'h0000, 16'sh8000);
        send_item(OP_WR_OUT, 13'h0000, 16'sh7fff);
        send_item(OP_EVAL, 13'h0aaa, 16'sh5555);
        for (int m = 0; m < 4; m++) begin
            set_mode(t_act'(m));
            send_item(OP_EVAL, 13'h1555, 16'sh7fff);
        end
        // Saturate the output sum low, then high.
        send_item(OP_WR_OUT, 13'h0000, 16'sh8000);
        send_item(OP_EVAL, 13'h0000, 16'sh0000);
        send_item(OP_WR_OUT, 13'(UNITS - 1), 16'sh7fff);
        send_item(OP_WR_WIN, 13'(IN_LEN - 1), 16'sh7fff);
        send_item(OP_WR_HID, 13'(HID_LEN - 1), 16'sh7fff);
        send_item(OP_EVAL, 13'h0000, 16'sh0000);
    endtask

    // Random writes with occasional evaluations; the mode changes between
    // chunks, and the last chunk runs without idle cycles.
    task automatic test_random();
        t_opcode          op;
        logic [12:0]      addr;
        logic signed [15:0] val;
        int               pick;
        for (int chunk = 0; chunk < 5; chunk++) begin
            set_mode(t_act'($urandom_range(0, 3)));
            calm = (chunk == 4);
            for (int k = 0; k < 170; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 7) op = OP_EVAL;
                else if (pick < 57) op = OP_WR_HID;
                else if (pick < 67) op = OP_WR_OUT;
                else op = OP_WR_WIN;
                case (op)
                    OP_WR_HID: addr = 13'($urandom_range(0, HID_LEN - 1));
                    OP_WR_OUT: addr = 13'($urandom_range(0, UNITS - 1));
                    OP_WR_WIN: addr = 13'($urandom_range(0, IN_LEN - 1));
                    default:   addr = 13'($urandom);
                endcase
                if ($urandom_range(0, 15) == 0) addr = 13'($urandom);
                val = (op == OP_WR_HID) ? rand_value(512) : rand_value(4096);
                if (op == OP_EVAL) val = 16'($urandom);
                send_item(op, addr, val);
                // Now and then hold off until every score is back.
                if (op == OP_EVAL && $urandom_range(0, 3) == 0) begin
                    in_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_scores.size() != 0) @(posedge i_clk);
                end
            end
        end
    endtask

    // Result side stalls in random bursts unless the run is calm.
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Each result transaction is checked against the oldest expected score.
    t_score next_score;
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_scores.size() == 0) begin
                report("score arrived with none expected");
            end else begin
                next_score = pending_scores.pop_front();
                if (out_ch.score !== next_score.score)
                    report($sformatf("score %0d, expected %0d",
                                     out_ch.score, next_score.score));
                if (out_ch.tag_decision !== next_score.tag_decision)
                    report($sformatf("tag_decision %0b, expected %0b",
                                     out_ch.tag_decision, next_score.tag_decision));
            end
        end
    end

    // Hang detection: any transaction on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatches             = 0;
        calm                   = 1'b0;
        act_mode               = ACT_TANH;
        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.opcode           <= OP_WR_HID;
        in_ch.address          <= '0;
        in_ch.value            <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.activation_mode <= ACT_TANH;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_stores();
        test_directed();
        test_random();

        drain_scores();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
